FILE: hw/rtl/rps_pkg.sv
// shared types and constants for the random permutation shuffler
package rps_pkg;

   localparam int WORD_W  = 31;
   localparam int CSR_W   = 9;
   localparam int OUT_W   = 8;
   localparam int EPOCH_W = 8;

   localparam logic [CSR_W-1:0]   SIZE_RESET = 9'd256;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

   typedef enum logic [8:0] {
      S_SWEEP = 9'b0_0000_0001,
      S_IDLE  = 9'b0_0000_0010,
      S_START = 9'b0_0000_0100,
      S_DIV   = 9'b0_0000_1000,
      S_RD_I  = 9'b0_0001_0000,
      S_RD_J  = 9'b0_0010_0000,
      S_WR_J  = 9'b0_0100_0000,
      S_WR_I  = 9'b0_1000_0000,
      S_EMIT  = 9'b1_0000_0000
   } state_type;

endpackage

FILE: hw/rtl/rps_ram.sv
// generic single write port, single read port ram with registered read
module rps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rps_mod_unit.sv
// radix-2 shift-subtract remainder unit, one dividend bit per cycle
module rps_mod_unit
   import rps_pkg::*;
#(
   parameter int DIV_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    div_wide;

   assign trial    = {rem_ff, shift_ff[WORD_W-1]};
   assign div_wide = {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(WORD_W);
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
         if (trial >= div_wide) begin
            rem_in = DIV_W'(trial - div_wide);
         end else begin
            rem_in = DIV_W'(trial);
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/random_permutation_shuffler.sv
// random permutation shuffler top level: sequencer, slot memory and remainder unit
//
// Builds a random permutation of 0..size-1 by a forward Fisher-Yates shuffle, one slot
// per request: slot i is swapped with slot i + random_word mod (size - i) and the value
// fixed at slot i is returned, with last set on the final slot of a run. Requests are
// accepted only in idle, so a request is not taken before the last one is through: a
// start step, 31 steps of the shift-subtract remainder unit and its done step, two
// reads and two writes on the slot memory, the result step and the return to idle.
// A request is accepted while the previous result still waits to be taken; the
// block then holds in its result step until that result goes. Slots carry a run tag
// instead of a cleared bitmap; after reset, and again at a run start each time the
// tag wraps (once every 255 runs), the block sweeps every slot of the memory with
// req_ready low (csr writes are still taken). perm_size of 0 acts as 1 and values above
// MAX_SIZE saturate; a size change applies at the next request and restarts the run if
// the current position no longer fits.
module random_permutation_shuffler
   import rps_pkg::*;
#(
   parameter int MAX_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_random_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_position,
   output logic [OUT_W-1:0]  rsp_element,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(MAX_SIZE);
   localparam int SZ_W  = $clog2(MAX_SIZE + 1);
   localparam int CMP_W = (SZ_W > CSR_W) ? SZ_W : CSR_W;
   localparam int EXT_W = (IDX_W > OUT_W) ? IDX_W : OUT_W;
   localparam int RAM_W = EPOCH_W + IDX_W;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]   perm_size_ff, perm_size_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic               resume_ff, resume_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [SZ_W-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]   vi_ff, vi_in;
   logic [IDX_W-1:0]   vj_ff, vj_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [OUT_W-1:0]   rsp_element_ff, rsp_element_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]   size_wide;
   logic [SZ_W-1:0]    size_eff;
   logic [IDX_W-1:0]   pos_start;
   logic               req_fire;
   logic               mod_start;
   logic               mod_done;
   logic [SZ_W-1:0]    mod_rem;
   logic [SZ_W-1:0]    mod_divisor;
   logic               is_last;
   logic [EXT_W-1:0]   pos_ext;
   logic [EXT_W-1:0]   elem_ext;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [RAM_W-1:0]   ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [RAM_W-1:0]   ram_rd_data;
   logic [EPOCH_W-1:0] rd_tag;
   logic [IDX_W-1:0]   rd_value;

   // effective size and run position
   always_comb begin
      size_wide = CMP_W'(perm_size_ff);
      if (perm_size_ff == '0) begin
         size_eff = SZ_W'(1);
      end else if (size_wide > CMP_W'(MAX_SIZE)) begin
         size_eff = SZ_W'(MAX_SIZE);
      end else begin
         size_eff = SZ_W'(size_wide);
      end
      pos_start = (SZ_W'(pos_ff) >= size_eff) ? '0 : pos_ff;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign mod_start   = (state_ff == S_START);
   assign mod_divisor = size_ff - SZ_W'(i_ff);
   assign is_last     = (SZ_W'(i_ff) == (size_ff - SZ_W'(1)));
   assign rd_tag      = ram_rd_data[RAM_W-1:IDX_W];
   assign rd_value    = ram_rd_data[IDX_W-1:0];
   assign pos_ext     = EXT_W'(i_ff);
   assign elem_ext    = EXT_W'(vj_ff);

   always_comb begin
      state_in        = state_ff;
      perm_size_in    = perm_size_ff;
      pos_in          = pos_ff;
      epoch_in        = epoch_ff;
      sweep_in        = sweep_ff;
      resume_in       = resume_ff;
      word_in         = word_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      size_in         = size_ff;
      vi_in           = vi_ff;
      vj_in           = vj_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_position_in = rsp_position_ff;
      rsp_element_in  = rsp_element_ff;
      rsp_last_in     = rsp_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = i_ff;
      ram_wr_data     = {epoch_ff, vj_ff};
      ram_rd_addr     = j_ff;

      if (csr_write_enable) begin
         perm_size_in = csr_write_data;
      end

      case (state_ff)
         S_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = {EPOCH_NONE, {IDX_W{1'b0}}};
            sweep_in    = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(MAX_SIZE - 1)) begin
               sweep_in  = '0;
               resume_in = 1'b0;
               state_in  = resume_ff ? S_START : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               word_in = req_random_word;
               i_in    = pos_start;
               size_in = size_eff;
               state_in = S_START;
               // new run: advance the tag, sweep when it runs out
               if (pos_start == '0) begin
                  if (epoch_ff == EPOCH_MAX) begin
                     epoch_in  = EPOCH_FIRST;
                     resume_in = 1'b1;
                     state_in  = S_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_FIRST;
                  end
               end
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (mod_done) begin
               j_in     = i_ff + IDX_W'(mod_rem);
               state_in = S_RD_I;
            end
         end
         S_RD_I: begin
            ram_rd_addr = i_ff;
            state_in    = S_RD_J;
         end
         S_RD_J: begin
            ram_rd_addr = j_ff;
            vi_in       = (rd_tag == epoch_ff) ? rd_value : i_ff;
            state_in    = S_WR_J;
         end
         S_WR_J: begin
            vj_in       = (rd_tag == epoch_ff) ? rd_value : j_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = {epoch_ff, vi_ff};
            state_in    = S_WR_I;
         end
         S_WR_I: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = {epoch_ff, vj_ff};
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = pos_ext[OUT_W-1:0];
               rsp_element_in  = elem_ext[OUT_W-1:0];
               rsp_last_in     = is_last;
               pos_in          = is_last ? '0 : i_ff + IDX_W'(1);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         perm_size_ff <= SIZE_RESET;
         pos_ff       <= '0;
         epoch_ff     <= EPOCH_NONE;
         sweep_ff     <= '0;
         resume_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         perm_size_ff <= perm_size_in;
         pos_ff       <= pos_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         resume_ff    <= resume_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff         <= word_in;
      i_ff            <= i_in;
      j_ff            <= j_in;
      size_ff         <= size_in;
      vi_ff           <= vi_in;
      vj_ff           <= vj_in;
      rsp_position_ff <= rsp_position_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_last_ff     <= rsp_last_in;
   end

   rps_mod_unit #(
      .DIV_W (SZ_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (word_ff),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   rps_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: hw/rtl/rps_checker.sv
// port-level checks for the random permutation shuffler and their bind
module rps_checker
   import rps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              csr_write_enable,
   input logic [CSR_W-1:0]  csr_write_data,
   input logic              req_valid,
   input logic              req_ready,
   input logic [WORD_W-1:0] req_random_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OUT_W-1:0]  rsp_position,
   input logic [OUT_W-1:0]  rsp_element,
   input logic              rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_element) && $stable(rsp_last))
      else $error("rsp changed while stalled");

   // busy for a while after each request
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready right after accept");

   a_busy_later: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##3 !req_ready)
      else $error("req_ready too soon after accept");

   // a fresh result shows up as the block goes back to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("rsp appeared while busy");

endmodule

bind random_permutation_shuffler rps_checker u_rps_checker (.*);

FILE: dv/tb_random_permutation_shuffler.sv
// testbench for the random permutation shuffler: requests checked against a predictor
`timescale 1ns / 100ps

module tb_random_permutation_shuffler
   import rps_pkg::*;
();

   localparam int SLOTS       = 256;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [OUT_W-1:0] position;
      logic [OUT_W-1:0] element;
      logic             last;
   } slot_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [CSR_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [WORD_W-1:0] req_random_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [OUT_W-1:0]  rsp_position;
   logic [OUT_W-1:0]  rsp_element;
   logic              rsp_last;

   // predictor state
   logic [CSR_W-1:0]  perm_size_shadow = SIZE_RESET;
   logic [7:0]        slot_values [SLOTS];
   bit                slot_touched [SLOTS];
   int unsigned       next_slot = 0;
   slot_result_type   expected_slots [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   random_permutation_shuffler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_element      (rsp_element),
      .rsp_last         (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned effective_size(input logic [CSR_W-1:0] sz);
      int unsigned n;
      n = 32'(sz);
      if (n == 0) n = 1;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   function automatic void shuffle_step(input logic [WORD_W-1:0] word);
      int unsigned n, i, j, vi, vj, w;
      slot_result_type r;
      n = effective_size(perm_size_shadow);
      w = 32'(word);
      i = next_slot;
      if (i >= n) i = 0;
      if (i == 0) begin
         foreach (slot_touched[k]) slot_touched[k] = 1'b0;
      end
      j = i + w % (n - i);
      vi = slot_touched[i] ? slot_values[i] : i;
      vj = slot_touched[j] ? slot_values[j] : j;
      slot_values[j] = vi[7:0];
      slot_touched[j] = 1'b1;
      slot_values[i] = vj[7:0];
      slot_touched[i] = 1'b1;
      r.last = (i == n - 1);
      next_slot = r.last ? 0 : i + 1;
      r.position = i[7:0];
      r.element = vj[7:0];
      expected_slots.push_back(r);
   endfunction

   function automatic void check_slot();
      slot_result_type exp_r;
      if (expected_slots.size() == 0) begin
         $display("%t unexpected result position %0d element %0d last %0d", $time,
                  rsp_position, rsp_element, rsp_last);
         mismatch_count++;
         return;
      end
      exp_r = expected_slots.pop_front();
      if (rsp_position !== exp_r.position) begin
         $display("%t position expected %0d actual %0d", $time, exp_r.position, rsp_position);
         mismatch_count++;
      end
      if (rsp_element !== exp_r.element) begin
         $display("%t element expected %0d actual %0d", $time, exp_r.element, rsp_element);
         mismatch_count++;
      end
      if (rsp_last !== exp_r.last) begin
         $display("%t last expected %0d actual %0d", $time, exp_r.last, rsp_last);
         mismatch_count++;
      end
   endfunction

   // result side: check and throttle
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) check_slot();
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shuffle_step(word);
   endtask

   task automatic send_random();
      logic [WORD_W-1:0] word;
      word = WORD_W'($urandom());
      send_word(word);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] sz);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= sz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      perm_size_shadow = sz;
   endtask

   task automatic test_default_size();
      send_word('0);
      send_word({WORD_W{1'b1}});
      send_word(31'h2AAA_AAAA);
      send_word(31'h5555_5555);
   endtask

   task automatic test_size_change_mid_run();
      // shrink below the current position restarts the run
      write_size(9'd3);
      repeat (4) send_random();
      // grow mid-run continues the run
      write_size(9'd200);
      repeat (2) send_random();
      write_size(9'd2);
      repeat (2) send_random();
   endtask

   task automatic test_size_extremes();
      write_size(9'd0);
      send_word({WORD_W{1'b1}});
      send_word('0);
      write_size(9'd1);
      repeat (2) send_random();
      write_size(9'd511);
      send_word({WORD_W{1'b1}});
      send_random();
      write_size(9'd257);
      send_random();
   endtask

   task automatic test_full_run();
      write_size(9'd256);
      repeat (SLOTS) send_random();
   endtask

   task automatic test_backpressure();
      write_size(9'd8);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 400;
      repeat (20) send_random();
      drain_results();
      repeat (12) send_random();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct_in,
                                      input int item_budget);
      int sent, eff, runs, count;
      logic [CSR_W-1:0] sz;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct_in;
      sent = 0;
      while (sent < item_budget) begin
         case ($urandom_range(9))
            0: sz = '0;
            1: sz = CSR_W'($urandom_range(257, 511));
            2: sz = CSR_W'($urandom_range(17, 64));
            default: sz = CSR_W'($urandom_range(1, 16));
         endcase
         write_size(sz);
         eff = effective_size(sz);
         if (eff > 64) begin
            count = $urandom_range(8, 40);
         end else begin
            runs = (eff > 32) ? 1 : $urandom_range(1, 3);
            count = eff * runs + $urandom_range(0, eff - 1);
         end
         repeat (count) send_random();
         sent += count;
      end
   endtask

   initial begin
      foreach (slot_touched[k]) slot_touched[k] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_size();
      test_size_change_mid_run();
      test_size_extremes();
      test_full_run();
      test_backpressure();
      test_random_traffic(0, 0, 300);
      test_random_traffic(70, 0, 300);
      test_random_traffic(0, 70, 300);
      test_random_traffic(26, 26, 300);
      drain_results();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && expected_slots.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
